>>> src/dram_capacity_decoder_top_assert.svh
// Assertion macros shared by the DRAM capacity decoder RTL.
// Define NO_ASSERTIONS to compile every macro below to nothing.
`ifndef DRAM_CAPACITY_DECODER_TOP_ASSERT_SVH
`define DRAM_CAPACITY_DECODER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge of clk while rst_n is high.
`define DCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, also while reset is applied.
`define DCD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DCD_ASSERT(label, prop, msg)
`define DCD_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

>>> src/dcd_pkg.sv
// Types and constants for the DRAM capacity decoder.
// No dependencies; imported by the lane, merge and top-level modules.
package dcd_pkg;

    localparam int NUM_LANES = 2;
    localparam int LANE_W    = 16;
    localparam int BYTES_W   = 38;
    localparam int TOTAL_W   = 39;
    localparam int CAP_W     = 36;
    localparam int KIND_W    = 5;
    localparam int VER_W     = 4;

    localparam logic [KIND_W-1:0] TYPE_MAX       = 5'd10;
    localparam logic [KIND_W-1:0] KIND_BG        = 5'd0;
    localparam logic [KIND_W-1:0] KIND_BANK_UP   = 5'd9;
    localparam logic [VER_W-1:0]  VER_NEW_ROWS   = 4'd2;
    localparam logic [VER_W-1:0]  VER_TYPE_EXT   = 4'd3;
    localparam logic [2:0]        ROW_CODE_SHORT = 3'd7;
    localparam logic [1:0]        WCODE_BAD      = 2'd3;
    localparam logic [1:0]        BG_CODE_TWO    = 2'd2;
    localparam logic [5:0]        EXP_MIN        = 6'd20;
    localparam logic [5:0]        EXP_MAX        = 6'd35;
    localparam logic signed [5:0] DELTA_MAX      = 6'sd8;

    localparam logic [TOTAL_W-1:0] TOTAL_MIN = TOTAL_W'(1) << 30;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(1) << 35;

    // Decode options that are common to all lanes of one item.
    typedef struct packed {
        logic new_rows;
        logic bank_up;
        logic bg_on;
    } lane_ctrl_t;

    typedef struct packed {
        logic               fail;
        logic [BYTES_W-1:0] bytes;
    } lane_result_t;

endpackage

>>> src/dcd_lane.sv
// One channel of the DRAM capacity decoder: sizes a single 16-bit lane.
// Depends on dcd_pkg.
module dcd_lane (
    input  logic [dcd_pkg::LANE_W-1:0] lane,
    input  logic                       row0_ext,
    input  logic                       row1_ext,
    input  logic [1:0]                 col1_code,
    input  logic                       quarter,
    input  dcd_pkg::lane_ctrl_t        ctrl,
    output dcd_pkg::lane_result_t      result
);
    import dcd_pkg::*;

    logic [2:0]         row0_code;
    logic [2:0]         row1_code;
    logic [4:0]         row0;
    logic [4:0]         row1;
    logic [3:0]         col0;
    logic [3:0]         col1;
    logic [2:0]         bank;
    logic [1:0]         bg;
    logic [1:0]         wcode;
    logic [5:0]         e;
    logic signed [5:0]  delta;
    logic               two_ranks;
    logic               delta_bad;
    logic [BYTES_W-1:0] base;
    logic [BYTES_W-1:0] ranked;
    logic [BYTES_W-1:0] quarter_part;

    always_comb
    begin
        row0_code = {row0_ext, lane[7:6]};
        row1_code = {row1_ext, lane[5:4]};
        col0      = 4'd9 + 4'(lane[10:9]);
        wcode     = lane[3:2];
        two_ranks = lane[11];

        if (ctrl.new_rows)
        begin
            row0 = (row0_code == ROW_CODE_SHORT) ? 5'd12 : 5'd13 + 5'(row0_code);
            row1 = (row1_code == ROW_CODE_SHORT) ? 5'd12 : 5'd13 + 5'(row1_code);
            col1 = 4'd9 + 4'(col1_code);
        end
        else
        begin
            row0 = 5'd13 + 5'(lane[7:6]);
            row1 = 5'd13 + 5'(lane[5:4]);
            col1 = col0;
        end

        bank = ctrl.bank_up ? 3'd3 + 3'(lane[8]) : 3'd3 - 3'(lane[8]);

        if (!ctrl.bg_on)
            bg = 2'd0;
        else if (lane[1:0] == BG_CODE_TWO)
            bg = 2'd2;
        else
            bg = 2'd1;

        e = 6'(row0) + 6'(col0) + 6'(bank) + 6'(bg) + 6'd2 - 6'(wcode);

        // Row plus column delta between the two ranks, -10 to 10.
        delta     = $signed(6'(row0) + 6'(col0) - 6'(row1) - 6'(col1));
        delta_bad = delta[5] || (delta > DELTA_MAX);

        base = BYTES_W'(1) << e;
        if (two_ranks)
            ranked = base + (base >> delta[3:0]);
        else
            ranked = base;

        quarter_part = ranked >> 2;

        result.fail = (wcode == WCODE_BAD) || (e < EXP_MIN) || (e > EXP_MAX)
                      || (two_ranks && delta_bad);
        result.bytes = quarter ? quarter_part + (quarter_part << 1) : ranked;
    end

endmodule

>>> src/dcd_merge.sv
// Merge stage of the DRAM capacity decoder: sums the lane sizes and checks bounds.
// Depends on dcd_pkg.
module dcd_merge (
    input  dcd_pkg::lane_result_t [dcd_pkg::NUM_LANES-1:0] lanes,
    input  logic [dcd_pkg::NUM_LANES-1:0]                  used,
    input  logic                                           kind_bad,
    output logic [dcd_pkg::CAP_W-1:0]                      capacity,
    output logic                                           ok
);
    import dcd_pkg::*;

    logic [TOTAL_W-1:0] total;
    logic               any_fail;

    always_comb
    begin
        total    = '0;
        any_fail = kind_bad;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            if (used[i])
            begin
                total    = total + TOTAL_W'(lanes[i].bytes);
                any_fail = any_fail | lanes[i].fail;
            end
        end
        ok       = !any_fail && (total >= TOTAL_MIN) && (total <= TOTAL_MAX);
        capacity = ok ? total[CAP_W-1:0] : '0;
    end

endmodule

>>> src/dram_capacity_decoder_top.sv
// DRAM capacity decoder. Takes one pair of memory-info words per cycle while
// in_ready is high and returns the total DRAM size in bytes with a valid flag,
// zero on any bad encoding. Throughput is one item per clock cycle when the
// output does not stall. Each item passes two registers: the accepting edge
// captures the two channel lanes, which decode in parallel, and the output
// register then captures the merge stage that sums and range-checks the channel
// sizes and drives the outputs. Output stalls back up through both stages without
// losing an item. Depends on dcd_pkg, dcd_lane, dcd_merge.
`include "dram_capacity_decoder_top_assert.svh"

module dram_capacity_decoder_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [31:0]                info_word_low,
    input  logic [31:0]                info_word_high,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [dcd_pkg::CAP_W-1:0]  capacity_bytes,
    output logic                       capacity_valid
);
    import dcd_pkg::*;

    logic [VER_W-1:0]  ver;
    logic [KIND_W-1:0] kind;
    lane_ctrl_t        ctrl;

    lane_result_t [NUM_LANES-1:0] lane_res;
    lane_result_t [NUM_LANES-1:0] lane_res_reg;
    logic [NUM_LANES-1:0]         used_reg;
    logic                         kind_bad_reg;
    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [CAP_W-1:0]             capacity_reg;
    logic                         ok_reg;

    logic [CAP_W-1:0] merge_capacity;
    logic             merge_ok;
    logic             in_fire;
    logic             s2_load;
    logic             cap_nonzero;
    logic             cap_in_range;

    always_comb
    begin
        ver  = info_word_high[31:28];
        kind = {(ver >= VER_TYPE_EXT) ? info_word_high[13:12] : 2'b00,
                info_word_low[15:13]};
        ctrl.new_rows = (ver >= VER_NEW_ROWS);
        ctrl.bank_up  = (kind == KIND_BANK_UP);
        ctrl.bg_on    = (kind == KIND_BG) && (ver != VER_TYPE_EXT);
    end

    for (genvar ch = 0; ch < NUM_LANES; ch++)
    begin : g_lane
        dcd_lane u_lane (
            .lane      (info_word_low[LANE_W*ch +: LANE_W]),
            .row0_ext  (info_word_high[5 + 2*ch]),
            .row1_ext  (info_word_high[4 + 2*ch]),
            .col1_code (info_word_high[2*ch +: 2]),
            .quarter   (info_word_low[30 + ch]),
            .ctrl      (ctrl),
            .result    (lane_res[ch])
        );
    end

    dcd_merge u_merge (
        .lanes    (lane_res_reg),
        .used     (used_reg),
        .kind_bad (kind_bad_reg),
        .capacity (merge_capacity),
        .ok       (merge_ok)
    );

    // The merge stage loads when the lane stage holds an item and the output register is empty or draining.
    assign s2_load  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s2_load;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s2_load)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s2_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            lane_res_reg <= lane_res;
            used_reg     <= {info_word_low[12], 1'b1};
            kind_bad_reg <= (kind > TYPE_MAX);
        end
        if (s2_load)
        begin
            capacity_reg <= merge_capacity;
            ok_reg       <= merge_ok;
        end
    end

    assign out_valid      = out_valid_reg;
    assign capacity_bytes = capacity_reg;
    assign capacity_valid = ok_reg;

    assign cap_nonzero  = (capacity_reg != '0);
    assign cap_in_range = (capacity_reg >= CAP_W'(TOTAL_MIN))
                          && (capacity_reg <= CAP_W'(TOTAL_MAX));

    `DCD_ASSERT(a_valid_flag, out_valid_reg |-> (ok_reg == cap_nonzero), "valid flag mismatch")
    `DCD_ASSERT(a_cap_range, (out_valid_reg && ok_reg) |-> cap_in_range, "capacity out of range")
    `DCD_ASSERT_ALWAYS(a_ready_full, !in_ready |-> s1_valid_reg, "stall with empty lane stage")
    `DCD_ASSERT(a_s1_hold, (s1_valid_reg && !in_ready) |=> s1_valid_reg, "stalled item dropped")

endmodule

>>> sim/dram_capacity_decoder_top_tb.sv
// Self-checking testbench for dram_capacity_decoder_top: directed word pairs, then random ones,
// with random idle gaps on the input and random stalls on the output.
// Depends on dcd_pkg and on the RTL under src.
module dram_capacity_decoder_top_tb;

    import dcd_pkg::*;

    typedef struct {
        logic [31:0]      lo;
        logic [31:0]      hi;
        bit               golden_known;
        logic [CAP_W-1:0] golden;
    } probe_t;

    localparam int NUM_PROBES  = 19;
    localparam int NUM_RANDOM  = 600;

    // Rows with golden_known set carry a hand-derived size; the rest use the predictor.
    probe_t directed_probes [0:NUM_PROBES-1] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 36'h0},            // all zero, total too small
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 36'h0},            // all ones, type too large
        '{32'h0000_20C0, 32'h0000_0000, 1'b1, 36'h0_4000_0000},  // smallest legal total
        '{32'h0000_20CC, 32'h0000_0000, 1'b1, 36'h0},            // width code three
        '{32'h0000_20C0, 32'h3000_2000, 1'b1, 36'h0},            // type extended past the limit
        '{32'h0000_06C2, 32'h0000_0000, 1'b1, 36'h8_0000_0000},  // largest legal total
        '{32'h0000_0EF2, 32'h0000_0000, 1'b1, 36'h0},            // second rank overflows total
        '{32'h0000_0682, 32'h2000_0020, 1'b1, 36'h0},            // exponent above the bound
        '{32'h0000_2830, 32'h0000_0000, 1'b1, 36'h0},            // negative rank delta
        '{32'h0000_2EB8, 32'h2000_0030, 1'b1, 36'h0},            // rank delta above eight
        '{32'h4000_20C0, 32'h0000_0000, 1'b1, 36'h0},            // three quarters drops below min
        '{32'h000C_30C0, 32'h0000_0000, 1'b1, 36'h0},            // width code three on lane one
        '{32'h0000_21C0, 32'h3000_1000, 1'b0, 36'h0},            // type nine, bank count up
        '{32'h0000_26C0, 32'h2000_0020, 1'b0, 36'h0},            // new encoding, row code seven
        '{32'hC0C0_30C0, 32'h0000_0000, 1'b0, 36'h0},            // two channels, both scaled
        '{32'h4000_22C0, 32'h0000_0000, 1'b0, 36'h0},            // three quarters, still legal
        '{32'h0000_28C0, 32'h0000_0000, 1'b0, 36'h0},            // second rank with a delta
        '{32'h0000_04C1, 32'h3000_0000, 1'b0, 36'h0},            // version three, no bank groups
        '{32'h0000_44C5, 32'h3000_1000, 1'b0, 36'h0}             // type ten
    };

    logic             clk;
    logic             rst_n          = 1'b0;
    logic             in_valid       = 1'b0;
    logic             in_ready;
    logic [31:0]      info_word_low  = '0;
    logic [31:0]      info_word_high = '0;
    logic             out_valid;
    logic             out_ready      = 1'b0;
    logic [CAP_W-1:0] capacity_bytes;
    logic             capacity_valid;

    logic [CAP_W-1:0] pending_capacity [$];
    int               mismatch_count = 0;
    bit               no_idle        = 1'b0;

    dram_capacity_decoder_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .info_word_low  (info_word_low),
        .info_word_high (info_word_high),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .capacity_bytes (capacity_bytes),
        .capacity_valid (capacity_valid)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Total DRAM size in bytes for one pair of info words, zero on a bad encoding.
    function automatic logic [CAP_W-1:0] predict_capacity(input logic [31:0] lo,
                                                          input logic [31:0] hi);
        logic [VER_W-1:0]   ver;
        logic [KIND_W-1:0]  kind;
        logic [15:0]        lane;
        logic [1:0]         wcode;
        logic [2:0]         rc;
        int unsigned        nch, row0, row1, col0, col1, bank, bg, e;
        int                 d;
        logic [BYTES_W-1:0] ch_bytes;
        logic [TOTAL_W-1:0] sum;
        ver  = hi[31:28];
        kind = {2'b00, lo[15:13]};
        if (ver >= VER_TYPE_EXT)
            kind[4:3] = hi[13:12];
        if (kind > TYPE_MAX)
            return '0;
        nch = lo[12] ? 2 : 1;
        sum = '0;
        for (int ch = 0; ch < nch; ch++)
        begin
            lane  = lo[ch*16 +: 16];
            col0  = 9 + lane[10:9];
            wcode = lane[3:2];
            bank  = (kind == KIND_BANK_UP) ? 3 + lane[8] : 3 - lane[8];
            bg    = 0;
            if (wcode == WCODE_BAD)
                return '0;
            if (ver < VER_NEW_ROWS)
            begin
                row0 = 13 + lane[7:6];
                row1 = 13 + lane[5:4];
                col1 = col0;
            end
            else
            begin
                // The new encoding borrows a third row bit from the high word.
                rc   = {hi[5 + 2*ch], lane[7:6]};
                row0 = (rc == ROW_CODE_SHORT) ? 12 : 13 + rc;
                rc   = {hi[4 + 2*ch], lane[5:4]};
                row1 = (rc == ROW_CODE_SHORT) ? 12 : 13 + rc;
                col1 = 9 + hi[2*ch +: 2];
            end
            if (kind == KIND_BG && ver != VER_TYPE_EXT)
                bg = (lane[1:0] == BG_CODE_TWO) ? 2 : 1;
            e = row0 + col0 + bank + bg + (2 - wcode);
            if (e < EXP_MIN || e > EXP_MAX)
                return '0;
            ch_bytes = BYTES_W'(1) << e;
            if (lane[11])
            begin
                d = (int'(row0) - int'(row1)) + (int'(col0) - int'(col1));
                if (d < 0 || d > DELTA_MAX)
                    return '0;
                ch_bytes += ch_bytes >> d;
            end
            if (lo[30 + ch])
                ch_bytes = (ch_bytes >> 2) * 3;
            sum += ch_bytes;
        end
        if (sum < TOTAL_MIN || sum > TOTAL_MAX)
            return '0;
        return sum[CAP_W-1:0];
    endfunction

    // Mostly short gaps, a few long ones, none at all during a burst stretch.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // A word pair that passes the type and width checks and often the rank check,
    // so that most items reach the size arithmetic.
    task automatic make_wellformed(output logic [31:0] lo, output logic [31:0] hi);
        logic [VER_W-1:0]  ver;
        logic [KIND_W-1:0] kind;
        ver  = VER_W'($urandom_range(0, 15));
        kind = (ver >= VER_TYPE_EXT) ? KIND_W'($urandom_range(0, TYPE_MAX))
                                     : KIND_W'($urandom_range(0, 7));
        lo   = $urandom;
        hi   = $urandom;
        hi[31:28] = ver;
        if (ver >= VER_TYPE_EXT)
            hi[13:12] = kind[4:3];
        lo[15:13] = kind[2:0];
        for (int ch = 0; ch < NUM_LANES; ch++)
        begin
            if (lo[ch*16 + 2 +: 2] == WCODE_BAD)
                lo[ch*16 + 2 +: 2] = 2'($urandom_range(0, 2));
            if ($urandom_range(0, 1) == 0)
            begin
                // Second rank shaped like the first: the rank delta is zero.
                lo[ch*16 + 4 +: 2] = lo[ch*16 + 6 +: 2];
                hi[4 + 2*ch]       = hi[5 + 2*ch];
                hi[2*ch +: 2]      = lo[ch*16 + 9 +: 2];
            end
        end
    endtask

    task automatic send_item(input logic [31:0] lo, input logic [31:0] hi,
                             input logic [CAP_W-1:0] expected);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        info_word_low  <= lo;
        info_word_high <= hi;
        do
            @(posedge clk);
        while (!in_ready);
        pending_capacity.push_back(expected);
    endtask

    initial
    begin
        logic [31:0] lo, hi;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_probes[i])
            send_item(directed_probes[i].lo, directed_probes[i].hi,
                      directed_probes[i].golden_known ? directed_probes[i].golden
                      : predict_capacity(directed_probes[i].lo, directed_probes[i].hi));

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n % 40 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0)
            begin
                lo = $urandom;
                hi = $urandom;
            end
            else
                make_wellformed(lo, hi);
            send_item(lo, hi, predict_capacity(lo, hi));
        end
        in_valid <= 1'b0;

        while (pending_capacity.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_capacity.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int gap;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            gap = idle_len();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        logic [CAP_W-1:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_capacity.size() == 0)
            begin
                $error("result with no item outstanding: capacity_bytes %0d", capacity_bytes);
                mismatch_count++;
            end
            else
            begin
                want = pending_capacity.pop_front();
                if (capacity_bytes !== want)
                begin
                    $error("capacity_bytes: expected %0d, got %0d", want, capacity_bytes);
                    mismatch_count++;
                end
                if (capacity_valid !== (want != '0))
                begin
                    $error("capacity_valid: expected %0b, got %0b", want != '0, capacity_valid);
                    mismatch_count++;
                end
            end
        end
    end

endmodule

>>> sim.f
+incdir+src
src/dcd_pkg.sv
src/dcd_lane.sv
src/dcd_merge.sv
src/dram_capacity_decoder_top.sv
sim/dram_capacity_decoder_top_tb.sv
